@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

  localparam int unsigned CFG_W = 63;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_VALUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_CHARS     = 3'd5;

  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_LETTER = 1'b1;

  localparam logic MODE_NUMERIC = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  localparam logic [13:0] VALUE_MAX = 14'd9999;
  localparam logic [3:0]  DIGIT_COUNT_RST = 4'd8;
  localparam logic [15:0] DIV10_MUL = 16'd6554;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [7:0]  SEG_BLANK = 8'hff;
  localparam logic [7:0]  POINT_MASK = 8'h7f;

  typedef struct packed {
    logic       cmd;
    logic [3:0] position;
    logic [6:0] letter;
  } ssd_in_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segments;
  } ssd_out_t;

  typedef struct packed {
    logic        display_mode;
    logic [13:0] upper_value;
    logic [13:0] lower_value;
    logic [3:0]  point_position;
    logic [3:0]  digit_count;
    logic [62:0] text_chars;
  } ssd_cfg_t;

  // one resolved item leaving the scan control
  typedef struct packed {
    logic       blank;
    logic       use_text;
    logic [2:0] slot;
    logic [6:0] code;
  } ssd_job_t;

  // 2^24 / 10^place rounded up, exact quotient for values up to 9999
  function automatic logic [20:0] ssd_recip(input logic [1:0] place);
    logic [20:0] r;
    case (place)
      2'd1:    r = 21'd1677722;
      2'd2:    r = 21'd167773;
      2'd3:    r = 21'd16778;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  // active-low for digits 0..9, active-high for the character entries
  function automatic logic [7:0] font_glyph(input logic [6:0] code);
    logic [7:0] g;
    case (code)
      7'd0:    g = 8'hc0;
      7'd1:    g = 8'hf9;
      7'd2:    g = 8'ha4;
      7'd3:    g = 8'hb0;
      7'd4:    g = 8'h99;
      7'd5:    g = 8'h92;
      7'd6:    g = 8'h82;
      7'd7:    g = 8'hf8;
      7'd8:    g = 8'h80;
      7'd9:    g = 8'h90;
      7'd33:   g = 8'h86;
      7'd34:   g = 8'h22;
      7'd39:   g = 8'h20;
      7'd40:   g = 8'h39;
      7'd41:   g = 8'h0f;
      7'd44:   g = 8'h80;
      7'd45:   g = 8'h40;
      7'd46:   g = 8'h80;
      7'd47:   g = 8'h52;
      7'd48:   g = 8'h3f;
      7'd49:   g = 8'h06;
      7'd50:   g = 8'h5b;
      7'd51:   g = 8'h4f;
      7'd52:   g = 8'h66;
      7'd53:   g = 8'h6d;
      7'd54:   g = 8'h7d;
      7'd55:   g = 8'h07;
      7'd56:   g = 8'h7f;
      7'd57:   g = 8'h6f;
      7'd61:   g = 8'h48;
      7'd63:   g = 8'h53;
      7'd64:   g = 8'h5f;
      7'd65:   g = 8'h77;
      7'd66:   g = 8'h7c;
      7'd67:   g = 8'h39;
      7'd68:   g = 8'h5e;
      7'd69:   g = 8'h79;
      7'd70:   g = 8'h71;
      7'd71:   g = 8'h3d;
      7'd72:   g = 8'h76;
      7'd73:   g = 8'h30;
      7'd74:   g = 8'h0e;
      7'd76:   g = 8'h38;
      7'd78:   g = 8'h37;
      7'd79:   g = 8'h3f;
      7'd80:   g = 8'h73;
      7'd81:   g = 8'h67;
      7'd82:   g = 8'h50;
      7'd83:   g = 8'h6d;
      7'd84:   g = 8'h78;
      7'd85:   g = 8'h3e;
      7'd86:   g = 8'h3e;
      7'd89:   g = 8'h6e;
      7'd90:   g = 8'h5b;
      7'd91:   g = 8'h39;
      7'd92:   g = 8'h64;
      7'd93:   g = 8'h0f;
      7'd94:   g = 8'h23;
      7'd95:   g = 8'h08;
      7'd96:   g = 8'h01;
      7'd97:   g = 8'h5f;
      7'd98:   g = 8'h7c;
      7'd99:   g = 8'h58;
      7'd100:  g = 8'h5e;
      7'd101:  g = 8'h7b;
      7'd102:  g = 8'h71;
      7'd103:  g = 8'h6f;
      7'd104:  g = 8'h74;
      7'd105:  g = 8'h10;
      7'd106:  g = 8'h0e;
      7'd108:  g = 8'h30;
      7'd110:  g = 8'h54;
      7'd111:  g = 8'h5c;
      7'd112:  g = 8'h73;
      7'd113:  g = 8'h67;
      7'd114:  g = 8'h50;
      7'd115:  g = 8'h6d;
      7'd116:  g = 8'h78;
      7'd117:  g = 8'h1c;
      7'd121:  g = 8'h6e;
      7'd122:  g = 8'h5b;
      7'd123:  g = 8'h39;
      7'd124:  g = 8'h30;
      7'd125:  g = 8'h0f;
      7'd126:  g = 8'h01;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/ssd_cfg_regs.sv @@
module ssd_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssd_pkg::CFG_W-1:0]          cfg_data_i,
  output ssd_pkg::ssd_cfg_t                  cfg_o
);

  ssd_pkg::ssd_cfg_t cfg_q, cfg_d;
  logic [13:0]       value_sat;

  // a low 14 bits above the four-digit range store the maximum; higher data bits are ignored
  assign value_sat = (cfg_data_i[13:0] > ssd_pkg::VALUE_MAX) ? ssd_pkg::VALUE_MAX
                                                             : cfg_data_i[13:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ssd_pkg::REG_DISPLAY_MODE:   cfg_d.display_mode   = cfg_data_i[0];
        ssd_pkg::REG_UPPER_VALUE:    cfg_d.upper_value    = value_sat;
        ssd_pkg::REG_LOWER_VALUE:    cfg_d.lower_value    = value_sat;
        ssd_pkg::REG_POINT_POSITION: cfg_d.point_position = cfg_data_i[3:0];
        ssd_pkg::REG_DIGIT_COUNT:    cfg_d.digit_count    = cfg_data_i[3:0];
        ssd_pkg::REG_TEXT_CHARS:     cfg_d.text_chars     = cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_mode   <= ssd_pkg::MODE_NUMERIC;
      cfg_q.upper_value    <= '0;
      cfg_q.lower_value    <= '0;
      cfg_q.point_position <= '0;
      cfg_q.digit_count    <= ssd_pkg::DIGIT_COUNT_RST;
      cfg_q.text_chars     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/ssd_scan_ctrl.sv @@
module ssd_scan_ctrl #(
  parameter int unsigned DIGITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ssd_pkg::ssd_in_t  item_i,
  input  ssd_pkg::ssd_cfg_t cfg_i,
  output ssd_pkg::ssd_job_t job_o
);

  localparam logic [3:0] DigitsW = 4'(DIGITS);

  logic [2:0] scan_slot_q, scan_slot_d;
  logic [3:0] limit;
  logic [2:0] slot_cur;
  logic [3:0] slot_inc;
  logic       pos_ok;

  always_comb begin
    if (cfg_i.display_mode == ssd_pkg::MODE_TEXT) begin
      limit = DigitsW;
    end else if (cfg_i.digit_count > DigitsW) begin
      limit = DigitsW;
    end else begin
      limit = cfg_i.digit_count;
    end
  end

  // a slot left beyond a shortened scan restarts at the rightmost digit
  assign slot_cur = ({1'b0, scan_slot_q} >= limit) ? 3'd0 : scan_slot_q;
  assign slot_inc = {1'b0, slot_cur} + 4'd1;
  assign pos_ok   = (item_i.position != 4'd0) && (item_i.position <= DigitsW);

  always_comb begin
    job_o = '0;
    if (item_i.cmd == ssd_pkg::CMD_LETTER) begin
      job_o.blank    = !pos_ok;
      job_o.use_text = 1'b1;
      job_o.slot     = item_i.position[2:0] - 3'd1;
      job_o.code     = item_i.letter;
    end else begin
      job_o.blank    = (limit == 4'd0);
      job_o.use_text = (cfg_i.display_mode == ssd_pkg::MODE_TEXT);
      job_o.slot     = slot_cur;
      job_o.code     = cfg_i.text_chars[{slot_cur, 3'b000} +: 7];
    end
  end

  always_comb begin
    scan_slot_d = scan_slot_q;
    if (accept_i && item_i.cmd == ssd_pkg::CMD_SCAN) begin
      scan_slot_d = (slot_inc >= limit) ? 3'd0 : slot_inc[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_slot_q <= '0;
    end else begin
      scan_slot_q <= scan_slot_d;
    end
  end

`ifndef ASSERT_OFF
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, scan_slot_q} < DigitsW)
    else $error("scan slot beyond digit range");

  a_letter_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.cmd == ssd_pkg::CMD_LETTER |=> $stable(scan_slot_q))
    else $error("one-shot letter moved the scan slot");
`endif

endmodule

@@ rtl/ssd_seg_pipe.sv @@
module ssd_seg_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  ssd_pkg::ssd_job_t job_i,
  input  ssd_pkg::ssd_cfg_t cfg_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssd_pkg::ssd_out_t out_item_o
);

  logic out_ready, s1_ready, s0_ready;

  // stage 0: resolved item
  logic              s0_v_q;
  ssd_pkg::ssd_job_t s0_job_q;

  // stage 1: quotient, select and glyph
  logic        s1_v_q;
  logic        s1_blank_q, s1_text_q, s1_point_q;
  logic [7:0]  s1_sel_q, s1_sel_d;
  logic [7:0]  s1_glyph_q, s1_glyph_d;
  logic [13:0] s1_quot_q, s1_quot_d;
  logic        s1_point_d;

  logic              out_v_q;
  ssd_pkg::ssd_out_t out_q, out_d;

  logic [13:0] value;
  logic [37:0] recip_prod;
  logic [29:0] div10_prod;
  logic [13:0] tens;
  logic [13:0] rem;
  logic [7:0]  digit_seg;

  assign out_ready   = !out_v_q || !out_stall_i;
  assign s1_ready    = !s1_v_q || out_ready;
  assign s0_ready    = !s0_v_q || s1_ready;
  assign job_ready_o = s0_ready;

  // stage 0 -> 1
  assign value      = s0_job_q.slot[2] ? cfg_i.upper_value : cfg_i.lower_value;
  assign recip_prod = 38'(value) * 38'(ssd_pkg::ssd_recip(s0_job_q.slot[1:0]));

  always_comb begin
    s1_quot_d  = (s0_job_q.slot[1:0] == 2'd0) ? value
                                              : recip_prod[ssd_pkg::RECIP_SHIFT +: 14];
    s1_sel_d   = ~(8'b1 << s0_job_q.slot);
    s1_glyph_d = ~ssd_pkg::font_glyph(s0_job_q.code);
    s1_point_d = (cfg_i.point_position == ({1'b0, s0_job_q.slot} + 4'd1));
  end

  // stage 1 -> output: quotient mod 10, then the digit font
  assign div10_prod = 30'(s1_quot_q) * 30'(ssd_pkg::DIV10_MUL);
  assign tens       = div10_prod[29:16];
  assign rem        = s1_quot_q - (tens << 3) - (tens << 1);
  assign digit_seg  = ssd_pkg::font_glyph({3'b000, rem[3:0]});

  always_comb begin
    out_d.digit_select = s1_sel_q;
    if (s1_blank_q) begin
      out_d.digit_select = ssd_pkg::SEG_BLANK;
      out_d.segments     = ssd_pkg::SEG_BLANK;
    end else if (s1_text_q) begin
      out_d.segments = s1_glyph_q;
    end else if (s1_point_q) begin
      out_d.segments = digit_seg & ssd_pkg::POINT_MASK;
    end else begin
      out_d.segments = digit_seg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_v_q <= job_valid_i;
      end
      if (s1_ready) begin
        s1_v_q <= s0_v_q;
      end
      if (out_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && job_valid_i) begin
      s0_job_q <= job_i;
    end
    if (s1_ready && s0_v_q) begin
      s1_blank_q <= s0_job_q.blank;
      s1_text_q  <= s0_job_q.use_text;
      s1_point_q <= s1_point_d;
      s1_sel_q   <= s1_sel_d;
      s1_glyph_q <= s1_glyph_d;
      s1_quot_q  <= s1_quot_d;
    end
    if (out_ready && s1_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_single_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $countones(~out_q.digit_select) <= 1)
    else $error("more than one digit selected");

  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.digit_select == ssd_pkg::SEG_BLANK |->
      out_q.segments == ssd_pkg::SEG_BLANK)
    else $error("segments lit with no digit selected");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_ready |-> out_v_q && out_stall_i)
    else $error("input stalled while the pipeline can move");
`endif

endmodule

@@ rtl/seven_segment_scan_driver_unit.sv @@
// Eight-digit multiplexed common-anode seven-segment scanner. Each item on the input
// channel is either a scan tick, which lights the next digit of the scan, or a one-shot
// letter at a given position; every item gives exactly one item of active-low digit
// select and segment pattern. Numeric mode shows upper_value and lower_value as four
// decimal digits each over the digit_count rightmost positions; text mode shows the
// eight character codes of text_chars. The block takes one item per clock while no
// output stall holds the pipeline; each result passes the item register, the quotient
// register and the output register in turn, and the decimal split uses a constant
// reciprocal multiply in the second stage and a divide-by-ten multiply in the third.
// Write configuration only while no item is in flight.
module seven_segment_scan_driver_unit #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ssd_pkg::ssd_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ssd_pkg::ssd_out_t             out_item_o
);

  ssd_pkg::ssd_cfg_t cfg;
  ssd_pkg::ssd_job_t job;
  logic              job_ready;
  logic              accept;

  assign in_stall_o = !job_ready;
  assign accept     = in_valid_i && job_ready;

  ssd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssd_scan_ctrl #(
    .DIGITS (DIGITS)
  ) u_scan_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .job_o    (job)
  );

  ssd_seg_pipe u_seg_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (in_valid_i),
    .job_ready_o (job_ready),
    .job_i       (job),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DIGITS = 8;
  localparam int unsigned PIPE_CYCLES = 6;
  localparam int unsigned GAP_MAX = 17;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_ITEMS = 100;
  // indexes past the last register, writes there must be ignored
  localparam logic [ssd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ssd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // font, entry 0 in the top byte; digits 0..9 are active-low, the rest active-high
  localparam logic [1023:0] FONT_BITS = {
    64'hc0f9a4b0999282f8, 64'h8090000000000000, 64'h0000000000000000,
    64'h0000000000000000, 64'h0086220000000020, 64'h390f000080408052,
    64'h3f065b4f666d7d07, 64'h7f6f000000480053, 64'h5f777c395e79713d,
    64'h76300e003800373f, 64'h7367506d783e3e00, 64'h006e5b39640f2308,
    64'h015f7c585e7b716f, 64'h74100e003000545c, 64'h7367506d781c0000,
    64'h006e5b39300f0100
  };

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ssd_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  ssd_pkg::ssd_in_t              in_item;
  logic                          out_valid;
  logic                          out_stall;
  ssd_pkg::ssd_out_t             out_item;

  // shadow copy of the display settings and scan position
  logic        shadow_mode;
  logic [13:0] shadow_upper;
  logic [13:0] shadow_lower;
  logic [3:0]  shadow_point;
  logic [3:0]  shadow_count;
  logic [62:0] shadow_text;
  logic [2:0]  shadow_slot;

  ssd_pkg::ssd_out_t display_q[$];
  int unsigned mismatch_count;
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned rx_hold;

  seven_segment_scan_driver_unit #(
    .DIGITS(DIGITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("seven_segment_scan_driver_unit test failed");
    $finish;
  end

  function automatic logic [7:0] font_byte(input logic [6:0] code);
    int idx;
    idx = int'(code);
    return FONT_BITS[1023 - 8 * idx -: 8];
  endfunction

  function automatic logic [13:0] clamp_value(input logic [ssd_pkg::CFG_W-1:0] data);
    return (data[13:0] > ssd_pkg::VALUE_MAX) ? ssd_pkg::VALUE_MAX : data[13:0];
  endfunction

  function automatic void apply_setting(input logic [ssd_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [ssd_pkg::CFG_W-1:0] data);
    case (idx)
      ssd_pkg::REG_DISPLAY_MODE:   shadow_mode = data[0];
      ssd_pkg::REG_UPPER_VALUE:    shadow_upper = clamp_value(data);
      ssd_pkg::REG_LOWER_VALUE:    shadow_lower = clamp_value(data);
      ssd_pkg::REG_POINT_POSITION: shadow_point = data[3:0];
      ssd_pkg::REG_DIGIT_COUNT:    shadow_count = data[3:0];
      ssd_pkg::REG_TEXT_CHARS:     shadow_text = data;
      default: ;
    endcase
  endfunction

  // what the display shows for one item; a scan tick also moves the scan position
  function automatic ssd_pkg::ssd_out_t predict_display(input ssd_pkg::ssd_in_t it);
    ssd_pkg::ssd_out_t r;
    int unsigned span;
    int unsigned slot;
    int unsigned val;
    int unsigned div;
    logic [6:0]  dig;
    r.digit_select = ssd_pkg::SEG_BLANK;
    r.segments = ssd_pkg::SEG_BLANK;
    if (it.cmd == ssd_pkg::CMD_LETTER) begin
      if (it.position >= 1 && it.position <= DIGITS) begin
        r.digit_select = ~(8'd1 << (it.position - 4'd1));
        r.segments = ~font_byte(it.letter);
      end
    end else begin
      if (shadow_mode == ssd_pkg::MODE_TEXT) span = DIGITS;
      else span = (shadow_count > DIGITS) ? DIGITS : 32'(shadow_count);
      slot = 32'(shadow_slot);
      if (span == 0) begin
        shadow_slot = 3'd0;
      end else begin
        if (slot >= span) slot = 0;
        r.digit_select = ~(8'd1 << slot);
        if (shadow_mode == ssd_pkg::MODE_TEXT) begin
          r.segments = ~font_byte(shadow_text[slot * 8 +: 7]);
        end else begin
          val = (slot < 4) ? 32'(shadow_lower) : 32'(shadow_upper);
          div = 1;
          repeat (slot % 4) div = div * 10;
          dig = 7'((val / div) % 10);
          r.segments = font_byte(dig);
          if (shadow_point == slot + 1) r.segments[7] = 1'b0;
        end
        shadow_slot = (slot + 1 >= span) ? 3'd0 : 3'(slot + 1);
      end
    end
    return r;
  endfunction

  function automatic ssd_pkg::ssd_in_t make_item(input logic cmd, input logic [3:0] pos,
                                                 input logic [6:0] letter);
    ssd_pkg::ssd_in_t it;
    it.cmd = cmd;
    it.position = pos;
    it.letter = letter;
    return it;
  endfunction

  function automatic ssd_pkg::ssd_in_t random_item();
    ssd_pkg::ssd_in_t it;
    it.cmd = ($urandom_range(0, 4) == 0) ? ssd_pkg::CMD_LETTER : ssd_pkg::CMD_SCAN;
    it.position = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
    it.letter = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic logic [ssd_pkg::CFG_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ssd_pkg::CFG_W'(ssd_pkg::VALUE_MAX);
      2:       return ssd_pkg::CFG_W'($urandom_range(10000, 16383));
      3:       return ssd_pkg::CFG_W'({$urandom, $urandom});
      default: return ssd_pkg::CFG_W'($urandom_range(0, 9999));
    endcase
  endfunction

  task automatic write_reg(input logic [ssd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    apply_setting(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays up between items unless a gap is drawn
  task automatic offer_item(input ssd_pkg::ssd_in_t it);
    int unsigned gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item <= random_item();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    display_q.push_back(predict_display(it));
  endtask

  task automatic settle_display();
    @(negedge clk);
    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // receiver: draws a stall before each item, or takes a requested long hold
  initial begin
    int unsigned n;
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin : check_display
    ssd_pkg::ssd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (display_q.size() == 0) begin
        $error("unexpected item: digit_select %h segments %h",
               out_item.digit_select, out_item.segments);
        mismatch_count++;
      end else begin
        want = display_q.pop_front();
        if (out_item.digit_select !== want.digit_select) begin
          $error("digit_select: expected %h, actual %h",
                 want.digit_select, out_item.digit_select);
          mismatch_count++;
        end
        if (out_item.segments !== want.segments) begin
          $error("segments: expected %h, actual %h", want.segments, out_item.segments);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_scan();
    repeat (2) offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
  endtask

  task automatic test_numeric_digits();
    write_reg(ssd_pkg::REG_UPPER_VALUE, 63'd10000);
    write_reg(ssd_pkg::REG_LOWER_VALUE, 63'd5678);
    write_reg(ssd_pkg::REG_POINT_POSITION, 63'd8);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    repeat (8) offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd15, 7'd127));
    settle_display();
  endtask

  // shrink the scan below the current position, then blank it, then oversize it
  task automatic test_scan_length();
    repeat (3) offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
    write_reg(ssd_pkg::REG_DIGIT_COUNT, 63'd2);
    write_reg(ssd_pkg::REG_POINT_POSITION, 63'd15);
    repeat (2) offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
    write_reg(ssd_pkg::REG_DIGIT_COUNT, 63'd0);
    offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
    write_reg(ssd_pkg::REG_DIGIT_COUNT, 63'd15);
    offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
  endtask

  task automatic test_text_mode();
    write_reg(ssd_pkg::REG_DISPLAY_MODE, 63'(ssd_pkg::MODE_TEXT));
    write_reg(ssd_pkg::REG_TEXT_CHARS, 63'h7f41_2d30_fa61_6e00);
    write_reg(ssd_pkg::REG_POINT_POSITION, 63'd2);
    repeat (2) offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
  endtask

  // out-of-range positions blank, and a letter leaves the scan where it was
  task automatic test_one_shot();
    offer_item(make_item(ssd_pkg::CMD_LETTER, 4'd0, 7'd65));
    offer_item(make_item(ssd_pkg::CMD_LETTER, 4'd1, 7'd127));
    offer_item(make_item(ssd_pkg::CMD_LETTER, 4'd8, 7'd0));
    offer_item(make_item(ssd_pkg::CMD_LETTER, 4'd9, 7'd48));
    offer_item(make_item(ssd_pkg::CMD_LETTER, 4'd15, 7'd72));
    offer_item(make_item(ssd_pkg::CMD_SCAN, 4'd0, 7'd0));
    settle_display();
  endtask

  task automatic test_random_phases();
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(ssd_pkg::REG_DISPLAY_MODE, 63'(ssd_pkg::MODE_NUMERIC));
          write_reg(ssd_pkg::REG_UPPER_VALUE, '0);
          write_reg(ssd_pkg::REG_LOWER_VALUE, '0);
          write_reg(ssd_pkg::REG_POINT_POSITION, '0);
          write_reg(ssd_pkg::REG_DIGIT_COUNT, 63'd1);
        end
        1: begin
          write_reg(ssd_pkg::REG_UPPER_VALUE, '1);
          write_reg(ssd_pkg::REG_LOWER_VALUE, '1);
          write_reg(ssd_pkg::REG_POINT_POSITION, '1);
          write_reg(ssd_pkg::REG_DIGIT_COUNT, '1);
        end
        2: begin
          write_reg(ssd_pkg::REG_DISPLAY_MODE, 63'(ssd_pkg::MODE_TEXT));
          write_reg(ssd_pkg::REG_TEXT_CHARS, '1);
        end
        default: begin
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_DISPLAY_MODE,
                      ($urandom_range(0, 2) == 0) ? 63'(ssd_pkg::MODE_TEXT)
                                                  : 63'(ssd_pkg::MODE_NUMERIC));
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_UPPER_VALUE, random_value());
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_LOWER_VALUE, random_value());
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_POINT_POSITION, 63'($urandom_range(0, 15)));
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_DIGIT_COUNT, ($urandom_range(0, 3) == 0)
                                                ? 63'($urandom_range(0, 15))
                                                : 63'($urandom_range(1, 8)));
          if ($urandom_range(0, 3) != 0)
            write_reg(ssd_pkg::REG_TEXT_CHARS, 63'({$urandom, $urandom}));
        end
      endcase
      tx_gap_max = (ph % 4 == 3) ? 0 : GAP_MAX;
      rx_gap_max = (ph % 4 == 1) ? 0 : GAP_MAX;
      if (ph % 5 == 4) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end
      repeat (PHASE_ITEMS) offer_item(random_item());
      settle_display();
    end
  endtask

  // sender keeps offering while the receiver sits out a long stretch
  task automatic test_backpressure();
    write_reg(ssd_pkg::REG_DISPLAY_MODE, 63'(ssd_pkg::MODE_NUMERIC));
    write_reg(ssd_pkg::REG_DIGIT_COUNT, 63'd8);
    tx_gap_max = 0;
    rx_gap_max = GAP_MAX;
    rx_hold = 80;
    repeat (40) offer_item(random_item());
    settle_display();
    tx_gap_max = GAP_MAX;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = ssd_pkg::REG_DISPLAY_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    mismatch_count = 0;
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
    rx_hold = 0;
    shadow_mode = ssd_pkg::MODE_NUMERIC;
    shadow_upper = '0;
    shadow_lower = '0;
    shadow_point = '0;
    shadow_count = ssd_pkg::DIGIT_COUNT_RST;
    shadow_text = '0;
    shadow_slot = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    test_reset_scan();
    test_numeric_digits();
    test_scan_length();
    test_text_mode();
    test_one_shot();
    test_random_phases();
    test_backpressure();
    settle_display();

    if (mismatch_count == 0 && display_q.size() == 0) begin
      $display("seven_segment_scan_driver_unit test passed");
    end else begin
      $display("seven_segment_scan_driver_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssd_pkg.sv
rtl/ssd_cfg_regs.sv
rtl/ssd_scan_ctrl.sv
rtl/ssd_seg_pipe.sv
rtl/seven_segment_scan_driver_unit.sv
tb/sv/tb_top.sv
